FILE: hdl/icsf_pkg.sv
// ----------------------------------------------------------------------------
// icsf_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// induced cycle subset finder.
// ----------------------------------------------------------------------------
package icsf_pkg;

   localparam int unsigned MAX_VERTICES_DEFAULT = 8;
   localparam int unsigned FUNC_W               = 2;
   localparam int unsigned VTX_W                = 4;
   localparam int unsigned SUBSET_W             = 8;
   localparam int unsigned MIN_CYCLE_LEN        = 3;

   localparam logic [VTX_W-1:0] VCOUNT_RESET = 4'd8;

   localparam logic REPLY_SOLVE = 1'b0;
   localparam logic REPLY_QUERY = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR    = 2'd0,
      FUNC_ADD_EDGE = 2'd1,
      FUNC_SOLVE    = 2'd2,
      FUNC_QUERY    = 2'd3
   } func_type;

   typedef struct packed {
      logic adj_clear;
      logic edge_add;
      logic capture;
      logic solve_start;
      logic solve_read;
      logic mask_write;
      logic query_read;
      logic query_eval;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic h_last;
      logic mask_in_full;
      logic mask_last;
      logic rsp_free;
   } status_type;

endpackage

FILE: hdl/icsf_ctrl.sv
// ----------------------------------------------------------------------------
// icsf_ctrl
// Sequencer: accepts request beats, steps the solve sweep over all subsets
// and end vertices, runs the query lookup (read, then evaluate), hands off to the output.
// ----------------------------------------------------------------------------
module icsf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [icsf_pkg::FUNC_W-1:0]   req_func,
   output logic                          req_ready,
   input  icsf_pkg::status_type          status,
   output icsf_pkg::cmd_type             cmd
);
   import icsf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE        = 6'b000001,
      ST_SOLVE_READ  = 6'b000010,
      ST_SOLVE_WRITE = 6'b000100,
      ST_QUERY_READ  = 6'b001000,
      ST_QUERY_EVAL  = 6'b010000,
      ST_FINISH      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (func_type'(req_func))
                  FUNC_CLEAR:    cmd.adj_clear = 1'b1;
                  FUNC_ADD_EDGE: cmd.edge_add  = 1'b1;
                  FUNC_SOLVE: begin
                     cmd.solve_start = 1'b1;
                     state_in        = ST_SOLVE_READ;
                  end
                  FUNC_QUERY:    state_in = ST_QUERY_READ;
               endcase
            end
         end
         ST_SOLVE_READ: begin
            // subsets reaching past vertex_count skip the reads and store zero
            if (status.mask_in_full) begin
               cmd.solve_read = 1'b1;
               if (status.h_last) begin
                  state_in = ST_SOLVE_WRITE;
               end
            end else begin
               state_in = ST_SOLVE_WRITE;
            end
         end
         ST_SOLVE_WRITE: begin
            cmd.mask_write = 1'b1;
            state_in = status.mask_last ? ST_FINISH : ST_SOLVE_READ;
         end
         ST_QUERY_READ: begin
            cmd.query_read = 1'b1;
            state_in       = ST_QUERY_EVAL;
         end
         ST_QUERY_EVAL: begin
            cmd.query_eval = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.solve_read, cmd.mask_write, cmd.query_read, cmd.query_eval,
                cmd.rsp_load, cmd.capture}))
      else $error("more than one sequencer command in one cycle");

   a_solve_enters_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.solve_start |=> state_ff == ST_SOLVE_READ)
      else $error("solve beat did not start the sweep");

endmodule

FILE: hdl/icsf_datapath.sv
// ----------------------------------------------------------------------------
// icsf_datapath
// Adjacency rows, vertex_count register, path memory (one word per subset,
// one row of end vertices per start vertex), sweep counters and output stage.
// ----------------------------------------------------------------------------
module icsf_datapath #(
   parameter int unsigned MAX_VERTICES = icsf_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [icsf_pkg::FUNC_W-1:0]     req_func,
   input  logic [icsf_pkg::VTX_W-1:0]      req_vertex_a,
   input  logic [icsf_pkg::VTX_W-1:0]      req_vertex_b,
   input  logic [icsf_pkg::SUBSET_W-1:0]   req_query_subset,
   input  logic                            csr_wr_en,
   input  logic [icsf_pkg::VTX_W-1:0]      csr_wr_data,
   input  icsf_pkg::cmd_type               cmd,
   output icsf_pkg::status_type            status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_has_cycle,
   output logic                            rsp_reply_kind
);
   import icsf_pkg::*;

   localparam int unsigned IDX_W  = $clog2(MAX_VERTICES);
   localparam int unsigned WORD_W = MAX_VERTICES * MAX_VERTICES;
   localparam int unsigned DEPTH  = 1 << MAX_VERTICES;

   logic [VTX_W-1:0]        vcount_ff, vcount_in;
   logic [MAX_VERTICES-1:0] adj_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adj_in [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]        h_ff, h_in;
   logic [IDX_W-1:0]        hd_ff, hd_in;
   logic                    pend_ff, pend_in;
   logic [WORD_W-1:0]       acc_ff, acc_in;
   logic [MAX_VERTICES-1:0] qset_ff, qset_in;
   logic                    kind_ff, kind_in;
   logic                    solved_ff, solved_in;
   logic                    verdict_ff, verdict_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_cycle_ff, rsp_cycle_in;
   logic                    rsp_kind_ff, rsp_kind_in;

   logic [WORD_W-1:0]       path_mem_ff [DEPTH];
   logic [WORD_W-1:0]       rd_data_ff;

   logic [MAX_VERTICES-1:0] full_mask;
   logic                    mask_in_full;
   logic [MAX_VERTICES-1:0] solve_addr;
   logic [MAX_VERTICES-1:0] rd_addr;
   logic                    rd_en;
   logic [WORD_W-1:0]       contrib;
   logic [WORD_W-1:0]       acc_next;
   logic [WORD_W-1:0]       base;
   logic [WORD_W-1:0]       wdata;
   logic                    q_any;
   logic                    verdict_calc;
   logic                    edge_ok;
   logic [VTX_W-1:0]        a_m1, b_m1;
   logic [IDX_W-1:0]        ia, ib;

   // vertices covered by the sweep; a count above the maximum covers all
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         full_mask[i] = (VTX_W'(i) < vcount_ff);
      end
   end

   assign mask_in_full = (mask_ff & ~full_mask) == '0;
   assign solve_addr   = mask_ff ^ (MAX_VERTICES'(1) << h_ff);
   assign rd_addr      = cmd.query_read ? qset_ff : solve_addr;
   assign rd_en        = cmd.solve_read | cmd.query_read;

   // paths ending at hd: predecessor subset word, any end adjacent to hd
   always_comb begin
      contrib = '0;
      for (int s = 0; s < MAX_VERTICES; s++) begin
         contrib[s*MAX_VERTICES + int'(hd_ff)] =
            mask_ff[hd_ff] && (|(rd_data_ff[s*MAX_VERTICES +: MAX_VERTICES] & adj_ff[hd_ff]));
      end
   end

   assign acc_next = pend_ff ? (acc_ff | contrib) : acc_ff;

   // single-vertex subsets seed the trivial path
   always_comb begin
      base = '0;
      for (int s = 0; s < MAX_VERTICES; s++) begin
         base[s*MAX_VERTICES + s] = mask_ff[s] && $onehot(mask_ff);
      end
   end

   assign wdata = mask_in_full ? (acc_next | base) : '0;

   // cycle closes when some start row has an end adjacent to the start
   always_comb begin
      q_any = 1'b0;
      for (int s = 0; s < MAX_VERTICES; s++) begin
         q_any = q_any | (|(rd_data_ff[s*MAX_VERTICES +: MAX_VERTICES] & adj_ff[s]));
      end
   end

   assign verdict_calc = solved_ff && ($countones(qset_ff) >= MIN_CYCLE_LEN) && q_any;

   assign a_m1    = req_vertex_a - VTX_W'(1);
   assign b_m1    = req_vertex_b - VTX_W'(1);
   assign ia      = a_m1[IDX_W-1:0];
   assign ib      = b_m1[IDX_W-1:0];
   assign edge_ok = (req_vertex_a != '0) && (req_vertex_a <= VTX_W'(MAX_VERTICES)) &&
                    (req_vertex_b != '0) && (req_vertex_b <= VTX_W'(MAX_VERTICES)) &&
                    (req_vertex_a != req_vertex_b);

   always_comb begin
      vcount_in = csr_wr_en ? csr_wr_data : vcount_ff;

      for (int v = 0; v < MAX_VERTICES; v++) begin
         adj_in[v] = cmd.adj_clear ? '0 : adj_ff[v];
      end
      if (cmd.edge_add && edge_ok) begin
         adj_in[ia][ib] = 1'b1;
         adj_in[ib][ia] = 1'b1;
      end

      mask_in = mask_ff;
      h_in    = h_ff;
      if (cmd.solve_start) begin
         mask_in = '0;
         h_in    = '0;
      end else if (cmd.mask_write) begin
         mask_in = mask_ff + MAX_VERTICES'(1);
         h_in    = '0;
      end else if (cmd.solve_read) begin
         h_in = status.h_last ? '0 : h_ff + IDX_W'(1);
      end

      hd_in   = cmd.solve_read ? h_ff : hd_ff;
      pend_in = cmd.solve_read;
      acc_in  = (cmd.solve_start || cmd.mask_write) ? '0 : acc_next;

      qset_in = cmd.capture ? MAX_VERTICES'(req_query_subset) : qset_ff;
      kind_in = cmd.capture ? ((req_func == FUNC_QUERY) ? REPLY_QUERY : REPLY_SOLVE)
                            : kind_ff;

      solved_in  = solved_ff | cmd.solve_start;
      verdict_in = cmd.solve_start ? 1'b0 : (cmd.query_eval ? verdict_calc : verdict_ff);

      rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_cycle_in = cmd.rsp_load ? verdict_ff : rsp_cycle_ff;
      rsp_kind_in  = cmd.rsp_load ? kind_ff : rsp_kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         adj_ff       <= '{default: '0};
         pend_ff      <= 1'b0;
         solved_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         adj_ff       <= adj_in;
         pend_ff      <= pend_in;
         solved_ff    <= solved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      h_ff         <= h_in;
      hd_ff        <= hd_in;
      acc_ff       <= acc_in;
      qset_ff      <= qset_in;
      kind_ff      <= kind_in;
      verdict_ff   <= verdict_in;
      rsp_cycle_ff <= rsp_cycle_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   // path memory: one write port for the sweep, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mask_write) begin
         path_mem_ff[mask_ff] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= path_mem_ff[rd_addr];
      end
   end

   assign status.h_last       = (h_ff == IDX_W'(MAX_VERTICES - 1));
   assign status.mask_in_full = mask_in_full;
   assign status.mask_last    = &mask_ff;
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_cycle  = rsp_cycle_ff;
   assign rsp_reply_kind = rsp_kind_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result beat overwritten");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.solve_read |-> mask_in_full)
      else $error("sweep read issued for a subset outside vertex_count");

   a_write_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.mask_write && mask_in_full) |-> (pend_ff && hd_ff == IDX_W'(MAX_VERTICES - 1)))
      else $error("subset word written before all end vertices were merged");

endmodule

FILE: hdl/induced_cycle_subset_finder.sv
// ----------------------------------------------------------------------------
// induced_cycle_subset_finder
// Clear and add-edge beats stay in idle; the next request is taken right after.
// Query: a path memory read state, an evaluate state, then the result is loaded.
// Solve: per subset inside vertex_count one memory read per end vertex plus the
// write; other subsets skip the reads and store zero.
// Reset: adjacency cleared, vertex_count = 8, queries answer 0 until a solve.
// ----------------------------------------------------------------------------
module induced_cycle_subset_finder #(
   parameter int unsigned MAX_VERTICES = icsf_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [icsf_pkg::FUNC_W-1:0]     req_func,
   input  logic [icsf_pkg::VTX_W-1:0]      req_vertex_a,
   input  logic [icsf_pkg::VTX_W-1:0]      req_vertex_b,
   input  logic [icsf_pkg::SUBSET_W-1:0]   req_query_subset,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_has_cycle,
   output logic                            rsp_reply_kind,
   input  logic                            csr_wr_en,
   input  logic [icsf_pkg::VTX_W-1:0]      csr_wr_data
);
   import icsf_pkg::*;

   cmd_type    cmd;
   status_type status;

   icsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   icsf_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_func         (req_func),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .req_query_subset (req_query_subset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_has_cycle    (rsp_has_cycle),
      .rsp_reply_kind   (rsp_reply_kind)
   );

endmodule

FILE: tb/induced_cycle_subset_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// induced_cycle_subset_finder_tb
// Self-checking bench: builds random graphs, runs the path solve at several
// vertex counts and checks every reply against a local path-table predictor.
// ----------------------------------------------------------------------------
module induced_cycle_subset_finder_tb;
   import icsf_pkg::*;

   localparam int NV          = MAX_VERTICES_DEFAULT;
   localparam int STALL_LIMIT = 20000;
   localparam int ITEM_TARGET = 280;

   typedef struct packed {
      logic has_cycle;
      logic reply_kind;
   } reply_type;

   class cycle_scoreboard;
      bit [NV-1:0]    adj [NV];
      bit [NV-1:0]    paths [1 << NV][NV];
      bit [VTX_W-1:0] vcount;
      reply_type      expected_q[$];
      int             errors;

      function new();
         vcount = VCOUNT_RESET;
         errors = 0;
      endfunction

      static function bit valid_edge(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
         return a >= 1 && a <= NV && b >= 1 && b <= NV && a != b;
      endfunction

      function void set_vertex_count(logic [VTX_W-1:0] v);
         vcount = v;
      endfunction

      function void add_expected(bit has_cycle, bit reply_kind);
         reply_type r;
         r.has_cycle  = has_cycle;
         r.reply_kind = reply_kind;
         expected_q   = {expected_q, r};
      endfunction

      // grow every recorded path by one neighbor outside its subset
      function void solve_paths();
         int          n;
         bit [NV-1:0] span, tails, reach;
         n = (vcount > NV) ? NV : int'(vcount);
         span = NV'((1 << n) - 1);
         foreach (paths[m, s]) paths[m][s] = '0;
         for (int s = 0; s < n; s++)
            paths[1 << s][s][s] = 1'b1;
         for (int mask = 1; mask <= int'(span); mask++) begin
            for (int s = 0; s < n; s++) begin
               tails = paths[mask][s];
               for (int e = 0; e < n; e++) begin
                  if (tails[e]) begin
                     reach = adj[e] & span & ~mask[NV-1:0];
                     for (int h = 0; h < n; h++)
                        if (reach[h]) paths[mask | (1 << h)][s][h] = 1'b1;
                  end
               end
            end
         end
      endfunction

      // a cycle exists when some covering path closes back to its start
      function bit eval_query(bit [NV-1:0] subset);
         if ($countones(subset) < MIN_CYCLE_LEN)
            return 1'b0;
         for (int s = 0; s < NV; s++)
            if ((paths[subset][s] & adj[s]) != '0) return 1'b1;
         return 1'b0;
      endfunction

      function void note_request(func_type f, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                                 logic [SUBSET_W-1:0] subset);
         case (f)
            FUNC_CLEAR: begin
               foreach (adj[i]) adj[i] = '0;
            end
            FUNC_ADD_EDGE: begin
               if (valid_edge(a, b)) begin
                  adj[a-1][b-1] = 1'b1;
                  adj[b-1][a-1] = 1'b1;
               end
            end
            FUNC_SOLVE: begin
               solve_paths();
               add_expected(1'b0, REPLY_SOLVE);
            end
            default: begin
               add_expected(eval_query(subset), REPLY_QUERY);
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_reply(logic has_cycle, logic reply_kind);
         reply_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("reply kind=%0b has_cycle=%0b with nothing pending",
                                      reply_kind, has_cycle));
            return;
         end
         want = expected_q.pop_front();
         if (reply_kind !== want.reply_kind)
            report_mismatch($sformatf("reply_kind %0b, expected %0b", reply_kind,
                                      want.reply_kind));
         if (has_cycle !== want.has_cycle)
            report_mismatch($sformatf("has_cycle %0b, expected %0b (kind %0b)", has_cycle,
                                      want.has_cycle, want.reply_kind));
      endtask

      task drain_check();
         if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", expected_q.size()));
      endtask
   endclass

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func         = '0;
   logic [VTX_W-1:0]    req_vertex_a     = '0;
   logic [VTX_W-1:0]    req_vertex_b     = '0;
   logic [SUBSET_W-1:0] req_query_subset = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic                rsp_has_cycle;
   logic                rsp_reply_kind;
   logic                csr_wr_en        = 1'b0;
   logic [VTX_W-1:0]    csr_wr_data      = '0;

   cycle_scoreboard sb;
   bit              no_idle      = 1'b0;
   int              items_issued = 0;
   int              idle_cycles  = 0;
   int              ready_hold   = 0;

   induced_cycle_subset_finder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .req_query_subset (req_query_subset),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_has_cycle    (rsp_has_cycle),
      .rsp_reply_kind   (rsp_reply_kind),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_stall_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_req_gap();
      if (no_idle || $urandom_range(0, 9) < 4) return 0;
      return pick_stall_len();
   endfunction

   function automatic logic [VTX_W-1:0] rand_vtx(input int lo, input int hi);
      return VTX_W'($urandom_range(lo, hi));
   endfunction

   function automatic logic [SUBSET_W-1:0] rand_subset();
      return SUBSET_W'($urandom);
   endfunction

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(func_type'(req_func), req_vertex_a, req_vertex_b,
                            req_query_subset);
         if (rsp_valid && rsp_ready)
            sb.check_reply(rsp_has_cycle, rsp_reply_kind);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   // reply side back-pressure
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_ready <= 1'b0;
         ready_hold = pick_stall_len();
      end else begin
         rsp_ready <= 1'b1;
         ready_hold = $urandom_range(0, 6);
      end
   end

   task automatic issue_request(input func_type f, input logic [VTX_W-1:0] a,
                                input logic [VTX_W-1:0] b, input logic [SUBSET_W-1:0] subset);
      int gap;
      gap = pick_req_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_vertex_a     <= a;
      req_vertex_b     <= b;
      req_query_subset <= subset;
      do @(posedge clock); while (!req_ready);
      items_issued++;
   endtask

   task automatic issue_edge(input int n);
      logic [VTX_W-1:0] a, b;
      if (n >= 2 && $urandom_range(0, 9) != 0) begin
         a = rand_vtx(1, n);
         b = rand_vtx(1, n);
      end else begin
         a = rand_vtx(0, 15);
         b = rand_vtx(0, 15);
      end
      issue_request(FUNC_ADD_EDGE, a, b, rand_subset());
   endtask

   task automatic issue_query(input logic [SUBSET_W-1:0] span);
      logic [SUBSET_W-1:0] subset;
      subset = rand_subset();
      if ($urandom_range(0, 3) != 0)
         subset &= span;
      issue_request(FUNC_QUERY, rand_vtx(0, 15), rand_vtx(0, 15), subset);
   endtask

   // wait for every reply, then idle before the next phase
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [VTX_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_vertex_count(v);
   endtask

   task automatic run_graph_phase(input logic [VTX_W-1:0] vc);
      int                  n;
      logic [SUBSET_W-1:0] span;
      n = (vc > NV) ? NV : int'(vc);
      span = SUBSET_W'((1 << n) - 1);
      if ($urandom_range(0, 4) != 0)
         issue_request(FUNC_CLEAR, rand_vtx(0, 15), rand_vtx(0, 15), rand_subset());
      repeat ($urandom_range(0, 2 * NV)) issue_edge(n);
      issue_request(FUNC_SOLVE, rand_vtx(0, 15), rand_vtx(0, 15), rand_subset());
      repeat ($urandom_range(3, 8)) issue_query(span);
      // change the graph but keep the old path table
      if ($urandom_range(0, 2) == 0) begin
         if ($urandom_range(0, 1) == 0)
            issue_request(FUNC_CLEAR, rand_vtx(0, 15), rand_vtx(0, 15), rand_subset());
         repeat ($urandom_range(1, 4)) issue_edge(n);
         repeat ($urandom_range(2, 5)) issue_query(span);
      end
      if ($urandom_range(0, 5) == 0)
         issue_request(func_type'(FUNC_W'($urandom_range(0, 3))), rand_vtx(0, 15),
                       rand_vtx(0, 15), rand_subset());
   endtask

   initial begin
      int               phase;
      logic [VTX_W-1:0] vc;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // query on the reset table
      issue_request(FUNC_QUERY, 0, 0, 8'hFF);
      issue_request(FUNC_ADD_EDGE, 1, 2, 8'h00);
      issue_request(FUNC_ADD_EDGE, 2, 3, 8'h00);
      issue_request(FUNC_ADD_EDGE, 3, 1, 8'h00);
      issue_request(FUNC_ADD_EDGE, 8, 7, 8'hFF);
      // self-loop and out of range endpoints are dropped
      issue_request(FUNC_ADD_EDGE, 4, 4, 8'h00);
      issue_request(FUNC_ADD_EDGE, 0, 5, 8'h00);
      issue_request(FUNC_ADD_EDGE, 9, 2, 8'h00);
      issue_request(FUNC_ADD_EDGE, 15, 15, 8'hFF);
      issue_request(FUNC_ADD_EDGE, 5, 0, 8'h00);
      issue_request(FUNC_SOLVE, 15, 15, 8'hFF);
      issue_request(FUNC_QUERY, 0, 0, 8'h07);
      issue_request(FUNC_QUERY, 15, 15, 8'h03);
      issue_request(FUNC_QUERY, 0, 0, 8'h00);
      issue_request(FUNC_QUERY, 0, 0, 8'hFF);
      issue_request(FUNC_QUERY, 0, 0, 8'hC0);
      // clear drops edges only, the path table survives
      issue_request(FUNC_CLEAR, 15, 15, 8'hFF);
      issue_request(FUNC_QUERY, 0, 0, 8'h07);
      issue_request(FUNC_ADD_EDGE, 2, 1, 8'h00);
      issue_request(FUNC_ADD_EDGE, 3, 2, 8'h00);
      issue_request(FUNC_ADD_EDGE, 1, 3, 8'h00);
      issue_request(FUNC_QUERY, 0, 0, 8'h07);
      settle();

      phase = 0;
      while (items_issued < ITEM_TARGET) begin
         case (phase)
            0: vc = 0;
            1: vc = 15;
            2: vc = 1;
            3: vc = 2;
            4: vc = 3;
            5: vc = 8;
            6: vc = 9;
            default: vc = ($urandom_range(0, 9) < 7) ? rand_vtx(3, 8) : rand_vtx(0, 15);
         endcase
         no_idle = (phase % 5 == 3);
         write_vertex_count(vc);
         run_graph_phase(vc);
         settle();
         phase++;
      end

      repeat (16) @(posedge clock);
      sb.drain_check();
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
hdl/icsf_pkg.sv
hdl/icsf_ctrl.sv
hdl/icsf_datapath.sv
hdl/induced_cycle_subset_finder.sv
tb/induced_cycle_subset_finder_tb.sv
